/* rtl/imm_pkg.sv */
// imm_pkg: shared types and constants of the int8 matrix multiply block
// request codes, register indexes, status codes, walk state type, dimension clamp
// no dependencies
package imm_pkg;

  localparam int unsigned DIM_W = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [1:0] REQ_WR_A = 2'd0;
  localparam logic [1:0] REQ_WR_B = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DEPTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* rtl/int8_matrix_multiply_top.sv */
// int8_matrix_multiply_top: int8 matrices A and B in on-chip memories, int32 dot products
// one multiply-accumulate per cycle over the inner dimension for each product read
// depends on imm_pkg
//
//  channel  direction  handshake                 beat
//  in       sink       in_valid_i / in_stall_o   req_type, row_index, col_index, element_value
//  out      source     out_valid_o / out_stall_i product_sum, status
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index, cfg_data
//
// a write beat is stored as it is accepted; an out-of-range read or a read with inner
// depth zero is answered in the cycle after acceptance; an in-range read is answered once the
// single shared multiply-accumulate has walked both memories one element per cycle.
// reset clears control and configuration registers only; memory content is undefined until written.
// a stalled output holds; writes go in while idle, reads wait for a free output register.
module int8_matrix_multiply_top
  import imm_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_INNER = 512,
  parameter int unsigned MAX_COLS  = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [8:0]            row_index_i,
  input  logic [8:0]            col_index_i,
  input  logic signed [7:0]     element_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    product_sum_o,
  output logic                  status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned A_AW = RW + KW;
  localparam int unsigned B_AW = KW + CW;
  localparam int unsigned A_DEPTH = 2 ** A_AW;
  localparam int unsigned B_DEPTH = 2 ** B_AW;

  // configuration
  logic [6:0] row_count_q;
  logic [9:0] inner_depth_q, column_count_q;
  logic [DIM_W-1:0] rows, depth, cols, depth_m1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 7'd64;
      inner_depth_q  <= 10'd512;
      column_count_q <= 10'd512;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT:    row_count_q    <= cfg_data_i[6:0];
        CFG_INNER_DEPTH:  inner_depth_q  <= cfg_data_i;
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows     = clamp_dim(DIM_W'(row_count_q), DIM_W'(MAX_ROWS));
  assign depth    = clamp_dim(DIM_W'(inner_depth_q), DIM_W'(MAX_INNER));
  assign cols     = clamp_dim(DIM_W'(column_count_q), DIM_W'(MAX_COLS));
  assign depth_m1 = depth - DIM_W'(1);

  // request decode
  state_e state_q, state_d;
  logic [DIM_W-1:0] row13, col13;
  logic in_accept, is_read, read_oor, read_short, a_ok, b_ok;
  logic out_free, out_load, walk_start;
  logic a_we, b_we;

  assign row13      = DIM_W'(row_index_i);
  assign col13      = DIM_W'(col_index_i);
  assign out_free   = !out_valid_o || !out_stall_i;
  assign is_read    = (req_type_i == REQ_READ);
  assign in_stall_o = (state_q != ST_IDLE) || (is_read && !out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign a_ok       = (row13 < rows) && (col13 < depth);
  assign b_ok       = (row13 < depth) && (col13 < cols);
  assign read_oor   = (row13 >= rows) || (col13 >= cols);
  assign read_short = read_oor || (depth == '0);

  assign a_we       = in_accept && (req_type_i == REQ_WR_A) && a_ok;
  assign b_we       = in_accept && (req_type_i == REQ_WR_B) && b_ok;
  assign walk_start = in_accept && is_read && !read_short;

  // walk over the inner dimension
  logic [KW-1:0] k_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          walk_last;
  logic          dat_vld_q, prd_vld_q;

  assign walk_last = (DIM_W'(k_q) == depth_m1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (walk_start) state_d = ST_WALK;
      ST_WALK:  if (walk_last) state_d = ST_FLUSH;
      ST_FLUSH: if (!dat_vld_q && !prd_vld_q) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      dat_vld_q <= 1'b0;
      prd_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dat_vld_q <= (state_q == ST_WALK);
      prd_vld_q <= dat_vld_q;
      if (walk_start) begin
        k_q <= '0;
      end else if (state_q == ST_WALK) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_start) begin
      row_q <= row13[RW-1:0];
      col_q <= col13[CW-1:0];
    end
  end

  // memories
  logic [7:0] a_mem [A_DEPTH];
  logic [7:0] b_mem [B_DEPTH];
  logic [A_AW-1:0] a_waddr, a_raddr;
  logic [B_AW-1:0] b_waddr, b_raddr;
  logic signed [7:0] a_rdata_q, b_rdata_q;

  assign a_waddr = {row13[RW-1:0], col13[KW-1:0]};
  assign b_waddr = {row13[KW-1:0], col13[CW-1:0]};
  assign a_raddr = {row_q, k_q};
  assign b_raddr = {k_q, col_q};

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= element_value_i;
    end
    a_rdata_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= element_value_i;
    end
    b_rdata_q <= b_mem[b_raddr];
  end

  // multiply, then accumulate
  logic signed [15:0] prod_q;
  logic signed [31:0] acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_rdata_q * b_rdata_q;
    if (walk_start) begin
      acc_q <= '0;
    end else if (prd_vld_q) begin
      acc_q <= acc_q + 32'(prod_q);
    end
  end

  // output register
  logic out_valid_q;
  logic signed [31:0] product_sum_q;
  logic status_q;

  assign out_load = (in_accept && is_read && read_short) || ((state_q == ST_DONE) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == ST_DONE) begin
        product_sum_q <= acc_q;
        status_q      <= STATUS_OK;
      end else begin
        product_sum_q <= '0;
        status_q      <= read_oor ? STATUS_OOR : STATUS_OK;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign product_sum_o = product_sum_q;
  assign status_o      = status_q;

  // checks
  a_mem_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_we || b_we) |-> (state_q == ST_IDLE))
    else $error("memory write outside idle");

  k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (DIM_W'(k_q) < depth))
    else $error("walk index beyond inner depth");

  done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!dat_vld_q && !prd_vld_q))
    else $error("result taken before pipeline drained");

  out_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q == ST_DONE) || $past(in_accept && is_read)))
    else $error("result beat without a read");

  no_read_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_accept)
    else $error("beat accepted during a walk");

endmodule
